>>> hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL files of the alpha/rate update block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every clock edge outside reset.
`define ASSERT_AT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Check that a condition in one cycle is followed by another in the next cycle.
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hw/rtl/earu_pkg.sv
// Types, constants, control codes and root table of the alpha/rate update block.
package earu_pkg;

	localparam int FRAC_BITS = 16;
	localparam int RATE_BITS = 40;
	localparam int WORK_BITS = 30;

	localparam int FRAC_W = FRAC_BITS + 1;
	localparam int WORK_W = WORK_BITS + 1;
	localparam int CNT_W  = $clog2(FRAC_BITS);
	localparam int K_W    = $clog2(FRAC_BITS + 1);
	localparam int E_W    = FRAC_BITS + K_W;
	localparam int MUL_W  = 32;
	localparam int PROD_W = 2 * MUL_W;
	localparam int RLO_W  = RATE_BITS / 2;
	localparam int ACC_W  = RLO_W + FRAC_W;
	localparam int FULL_W = ACC_W + RLO_W + 1;
	localparam int EW_W   = 2 * FRAC_W;
	localparam int SH_W   = 6;

	localparam int CFG_IDX_W = 1;
	localparam int CFG_W     = RATE_BITS;

	localparam logic [FRAC_W-1:0]    ONE           = {1'b1, {FRAC_BITS{1'b0}}};
	localparam logic [EW_W-1:0]      HALF          = EW_W'(1) << (FRAC_BITS - 1);
	localparam logic [WORK_W-1:0]    W_ONE         = {1'b1, {WORK_BITS{1'b0}}};
	localparam logic [FRAC_W-1:0]    GAMMA_RST     = FRAC_W'(40960);
	localparam logic [RATE_BITS-1:0] INIT_RATE_RST = RATE_BITS'(10000000);

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_GAMMA     = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_INIT_RATE = 1'd1;

	// multiplier operand selects
	localparam logic [2:0] MUL_NONE = 3'd0;
	localparam logic [2:0] MUL_G1A  = 3'd1;
	localparam logic [2:0] MUL_GR   = 3'd2;
	localparam logic [2:0] MUL_MM   = 3'd3;
	localparam logic [2:0] MUL_WL   = 3'd4;
	localparam logic [2:0] MUL_VC   = 3'd5;
	localparam logic [2:0] MUL_RLO  = 3'd6;
	localparam logic [2:0] MUL_RHI  = 3'd7;

	// datapath actions
	localparam logic [3:0] ACT_NONE      = 4'd0;
	localparam logic [3:0] ACT_LATCH     = 4'd1;
	localparam logic [3:0] ACT_ACC_LOAD  = 4'd2;
	localparam logic [3:0] ACT_EWMA      = 4'd3;
	localparam logic [3:0] ACT_POW_INIT  = 4'd4;
	localparam logic [3:0] ACT_NORM      = 4'd5;
	localparam logic [3:0] ACT_SQ        = 4'd6;
	localparam logic [3:0] ACT_LOG_DONE  = 4'd7;
	localparam logic [3:0] ACT_E_DONE    = 4'd8;
	localparam logic [3:0] ACT_EXP_STEP  = 4'd9;
	localparam logic [3:0] ACT_EXP_DONE  = 4'd10;
	localparam logic [3:0] ACT_RATE_DONE = 4'd11;

	typedef struct packed {
		logic [2:0] mul;
		logic [3:0] act;
		logic       en;
	} ctl_t;

	typedef struct packed {
		logic marked;
		logic trivial;
		logic unnorm;
		logic loop;
	} stat_t;

	typedef logic [FRAC_BITS-1:0][WORK_BITS-1:0] root_tab_t;

	function automatic logic [63:0] isqrt64(logic [63:0] x_in);
		logic [63:0] x;
		logic [63:0] res;
		logic [63:0] b;
		x = x_in;
		res = '0;
		b = 64'd1 << 62;
		for (int n = 0; n < 32; n++) begin
			if (b != '0) begin
				if (x >= res + b) begin
					x = x - (res + b);
					res = (res >> 1) + b;
				end else begin
					res = res >> 1;
				end
				b = b >> 2;
			end
		end
		return res;
	endfunction

	// Entry i holds 2^(-2^-(FRAC_BITS-i)) with WORK_BITS fraction bits.
	function automatic root_tab_t build_roots();
		root_tab_t   tab;
		logic [63:0] c;
		c = 64'd1 << (WORK_BITS - 1);
		tab = '0;
		for (int j = 1; j <= FRAC_BITS; j++) begin
			c = isqrt64(c << WORK_BITS);
			tab[FRAC_BITS - j] = c[WORK_BITS-1:0];
		end
		return tab;
	endfunction

	localparam root_tab_t C_TAB = build_roots();

endpackage

>>> hw/rtl/ecn_alpha_rate_update.sv
// Top level of the marked-fraction estimate and tunnel rate update block.
//
//  channel  | handshake               | payload
//  ---------+-------------------------+------------------------------------------
//  cfg      | cfg_we (write, no wait) | cfg_index, cfg_data
//  in       | in_valid / in_ready     | marked_ratio, any_marked, weight
//  out      | out_valid / out_ready   | new_rate, new_alpha
//
// One request at a time runs a microcoded program on one shared 32x32 multiplier.
// An unmarked request skips the power and a trivial power skips both loops; a full power
// normalizes alpha (k = normalization shift of alpha, 1 to 16) and runs two 16-round loops.
// The next request can be taken as soon as the result is in the output register.
// Reset loads alpha with one and the rate with 10000000; an initial rate write reloads it.
// A stalled output holds only the final step; a new request still runs while the register is full.
`include "assert_macros.svh"

module ecn_alpha_rate_update import earu_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_W-1:0]      cfg_data,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [FRAC_W-1:0]     marked_ratio,
	input  logic                  any_marked,
	input  logic [FRAC_W-1:0]     weight,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [RATE_BITS-1:0]  new_rate,
	output logic [FRAC_W-1:0]     new_alpha
);

	logic [FRAC_W-1:0]    gamma_q;
	logic                 cfg_rate_we;
	ctl_t                 ctl;
	stat_t                stat;
	logic [FRAC_W-1:0]    alpha;
	logic [RATE_BITS-1:0] rate_next;
	logic                 out_valid_q;
	logic [RATE_BITS-1:0] new_rate_q;
	logic [FRAC_W-1:0]    new_alpha_q;
	logic                 out_busy;
	logic                 out_load;

	// Configuration: gamma is kept raw and clamped at use.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gamma_q <= GAMMA_RST;
		end else if (cfg_we && (cfg_index == REG_GAMMA)) begin
			gamma_q <= cfg_data[FRAC_W-1:0];
		end
	end

	// The initial rate goes straight into the rate state.
	assign cfg_rate_we = cfg_we && (cfg_index == REG_INIT_RATE);

	// Output register is busy while it holds a result nobody takes this cycle.
	assign out_busy = out_valid_q && !out_ready;
	assign out_load = ctl.en && (ctl.act == ACT_RATE_DONE);

	earu_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.out_busy (out_busy),
		.stat     (stat),
		.ctl      (ctl),
		.in_ready (in_ready)
	);

	earu_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctl          (ctl),
		.gamma        (gamma_q),
		.cfg_rate_we  (cfg_rate_we),
		.cfg_rate     (cfg_data[RATE_BITS-1:0]),
		.marked_ratio (marked_ratio),
		.any_marked   (any_marked),
		.weight       (weight),
		.stat         (stat),
		.alpha        (alpha),
		.rate_next    (rate_next)
	);

	// Set on the final program step, drop once the result is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			new_rate_q <= rate_next;
			new_alpha_q <= alpha;
		end
	end

	assign out_valid = out_valid_q;
	assign new_rate = new_rate_q;
	assign new_alpha = new_alpha_q;

	`ASSERT_AT_CLK(a_out_load_free, out_load |-> !out_busy, "result written over a pending one")
	`ASSERT_AT_CLK(a_alpha_bound, out_valid_q |-> (new_alpha_q <= ONE), "alpha above one")
	`ASSERT_NEXT(a_leave_idle, in_valid && in_ready, !in_ready, "sequencer stayed idle after a request")

endmodule

>>> hw/rtl/earu_seq.sv
// Microcode sequencer: step counter, control ROM and next-step logic.
`include "assert_macros.svh"

module earu_seq import earu_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	input  logic  out_busy,
	input  stat_t stat,
	output ctl_t  ctl,
	output logic  in_ready
);

	localparam int PC_W = 5;

	localparam logic [1:0] HOLD_NONE = 2'd0;
	localparam logic [1:0] HOLD_IN   = 2'd1;
	localparam logic [1:0] HOLD_OUT  = 2'd2;

	localparam logic [2:0] J_NEVER    = 3'd0;
	localparam logic [2:0] J_ALWAYS   = 3'd1;
	localparam logic [2:0] J_UNMARKED = 3'd2;
	localparam logic [2:0] J_TRIVIAL  = 3'd3;
	localparam logic [2:0] J_UNNORM   = 3'd4;
	localparam logic [2:0] J_LOOP     = 3'd5;

	localparam logic [PC_W-1:0] ST_IDLE     = 5'd0;
	localparam logic [PC_W-1:0] ST_MUL_OLD  = 5'd1;
	localparam logic [PC_W-1:0] ST_MUL_NEW  = 5'd2;
	localparam logic [PC_W-1:0] ST_EWMA     = 5'd3;
	localparam logic [PC_W-1:0] ST_POW      = 5'd4;
	localparam logic [PC_W-1:0] ST_NORM     = 5'd5;
	localparam logic [PC_W-1:0] ST_SQ_MUL   = 5'd6;
	localparam logic [PC_W-1:0] ST_SQ_STEP  = 5'd7;
	localparam logic [PC_W-1:0] ST_LOG_DONE = 5'd8;
	localparam logic [PC_W-1:0] ST_WL_MUL   = 5'd9;
	localparam logic [PC_W-1:0] ST_E_DONE   = 5'd10;
	localparam logic [PC_W-1:0] ST_EXP_MUL  = 5'd11;
	localparam logic [PC_W-1:0] ST_EXP_STEP = 5'd12;
	localparam logic [PC_W-1:0] ST_EXP_DONE = 5'd13;
	localparam logic [PC_W-1:0] ST_RATE_LO  = 5'd14;
	localparam logic [PC_W-1:0] ST_RATE_HI  = 5'd15;
	localparam logic [PC_W-1:0] ST_RATE     = 5'd16;
	localparam logic [PC_W-1:0] ST_LAST     = ST_RATE;

	typedef struct packed {
		logic [1:0]      hold;
		logic [2:0]      jmp;
		logic [PC_W-1:0] tgt;
		logic [2:0]      mul;
		logic [3:0]      act;
	} uword_t;

	function automatic uword_t rom(logic [PC_W-1:0] a);
		uword_t w;
		w = '{hold: HOLD_NONE, jmp: J_NEVER, tgt: ST_IDLE, mul: MUL_NONE, act: ACT_NONE};
		unique case (a)
			ST_IDLE: begin
				w.hold = HOLD_IN;
				w.act = ACT_LATCH;
			end
			ST_MUL_OLD:  w.mul = MUL_G1A;
			ST_MUL_NEW: begin
				w.mul = MUL_GR;
				w.act = ACT_ACC_LOAD;
			end
			ST_EWMA: begin
				w.act = ACT_EWMA;
				w.jmp = J_UNMARKED;
				w.tgt = ST_RATE_LO;
			end
			ST_POW: begin
				w.act = ACT_POW_INIT;
				w.jmp = J_TRIVIAL;
				w.tgt = ST_RATE_LO;
			end
			ST_NORM: begin
				w.act = ACT_NORM;
				w.jmp = J_UNNORM;
				w.tgt = ST_NORM;
			end
			ST_SQ_MUL:   w.mul = MUL_MM;
			ST_SQ_STEP: begin
				w.act = ACT_SQ;
				w.jmp = J_LOOP;
				w.tgt = ST_SQ_MUL;
			end
			ST_LOG_DONE: w.act = ACT_LOG_DONE;
			ST_WL_MUL:   w.mul = MUL_WL;
			ST_E_DONE:   w.act = ACT_E_DONE;
			ST_EXP_MUL:  w.mul = MUL_VC;
			ST_EXP_STEP: begin
				w.act = ACT_EXP_STEP;
				w.jmp = J_LOOP;
				w.tgt = ST_EXP_MUL;
			end
			ST_EXP_DONE: w.act = ACT_EXP_DONE;
			ST_RATE_LO:  w.mul = MUL_RLO;
			ST_RATE_HI: begin
				w.mul = MUL_RHI;
				w.act = ACT_ACC_LOAD;
			end
			ST_RATE: begin
				w.hold = HOLD_OUT;
				w.act = ACT_RATE_DONE;
				w.jmp = J_ALWAYS;
				w.tgt = ST_IDLE;
			end
			default: begin
				w.jmp = J_ALWAYS;
				w.tgt = ST_IDLE;
			end
		endcase
		return w;
	endfunction

	logic [PC_W-1:0] pc_q;
	uword_t          uw;
	logic            hold;
	logic            jump;

	assign uw = rom(pc_q);

	always_comb begin
		hold = ((uw.hold == HOLD_IN) && !in_valid) || ((uw.hold == HOLD_OUT) && out_busy);
		unique case (uw.jmp)
			J_NEVER:    jump = 1'b0;
			J_ALWAYS:   jump = 1'b1;
			J_UNMARKED: jump = !stat.marked;
			J_TRIVIAL:  jump = stat.trivial;
			J_UNNORM:   jump = stat.unnorm;
			J_LOOP:     jump = stat.loop;
			default:    jump = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= ST_IDLE;
		end else if (!hold) begin
			pc_q <= jump ? uw.tgt : pc_q + PC_W'(1);
		end
	end

	assign ctl.mul = uw.mul;
	assign ctl.act = uw.act;
	assign ctl.en = !hold;
	assign in_ready = (pc_q == ST_IDLE);

	`ASSERT_AT_CLK(a_pc_range, pc_q <= ST_LAST, "step counter left the program")
	`ASSERT_AT_CLK(a_hold_steps, !ctl.en |-> ((pc_q == ST_IDLE) || (pc_q == ST_RATE)), "stall outside a waiting step")
	`ASSERT_NEXT(a_accept_step, in_valid && in_ready, pc_q == ST_MUL_OLD, "program did not start after a request")

endmodule

>>> hw/rtl/earu_dp.sv
// Datapath: shared multiplier, work registers, alpha and rate state.
module earu_dp import earu_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  ctl_t                  ctl,
	input  logic [FRAC_W-1:0]     gamma,
	input  logic                  cfg_rate_we,
	input  logic [RATE_BITS-1:0]  cfg_rate,
	input  logic [FRAC_W-1:0]     marked_ratio,
	input  logic                  any_marked,
	input  logic [FRAC_W-1:0]     weight,
	output stat_t                 stat,
	output logic [FRAC_W-1:0]     alpha,
	output logic [RATE_BITS-1:0]  rate_next
);

	logic [FRAC_W-1:0]    g_c;
	logic [FRAC_W-1:0]    ratio_q;
	logic [FRAC_W-1:0]    w_q;
	logic                 marked_q;
	logic [FRAC_W-1:0]    alpha_q;
	logic [FRAC_W-1:0]    p_q;
	logic [RATE_BITS-1:0] rate_q;
	logic [WORK_W-1:0]    m_q;
	logic [K_W-1:0]       k_q;
	logic [FRAC_BITS-1:0] frac_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [E_W-1:0]       e_q;
	logic [PROD_W-1:0]    prod_q;
	logic [ACC_W-1:0]     acc_q;

	logic [MUL_W-1:0]     mul_a;
	logic [MUL_W-1:0]     mul_b;
	logic [FRAC_W-1:0]    f_sel;
	logic [EW_W-1:0]      ewma_sum;
	logic [EW_W-FRAC_BITS-1:0] ewma_val;
	logic [FRAC_W-1:0]    alpha_new;
	logic [WORK_W:0]      sq_t;
	logic [WORK_W-1:0]    vc_t;
	logic [FRAC_BITS-1:0] e_frac;
	logic [SH_W-1:0]      exp_sh;
	logic [WORK_W-1:0]    exp_val;
	logic [FULL_W-1:0]    full;
	logic [RATE_BITS-1:0] dec;
	logic [RATE_BITS:0]   inc;
	logic [RATE_BITS:0]   sum;

	assign g_c = (gamma > ONE) ? ONE : gamma;
	assign f_sel = marked_q ? p_q : w_q;

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (ctl.mul)
			MUL_NONE: ;
			MUL_G1A: begin
				mul_a = MUL_W'(ONE - g_c);
				mul_b = MUL_W'(alpha_q);
			end
			MUL_GR: begin
				mul_a = MUL_W'(g_c);
				mul_b = MUL_W'(ratio_q);
			end
			MUL_MM: begin
				mul_a = MUL_W'(m_q);
				mul_b = MUL_W'(m_q);
			end
			MUL_WL: begin
				mul_a = MUL_W'(w_q);
				mul_b = MUL_W'(e_q);
			end
			MUL_VC: begin
				mul_a = MUL_W'(m_q);
				mul_b = MUL_W'(C_TAB[cnt_q]);
			end
			MUL_RLO: begin
				mul_a = MUL_W'(rate_q[RLO_W-1:0]);
				mul_b = MUL_W'(f_sel);
			end
			MUL_RHI: begin
				mul_a = MUL_W'(rate_q[RATE_BITS-1:RLO_W]);
				mul_b = MUL_W'(f_sel);
			end
		endcase
	end

	// EWMA with rounding; the result cannot pass one but clamp it anyway
	assign ewma_sum = EW_W'(acc_q) + EW_W'(prod_q) + HALF;
	assign ewma_val = ewma_sum[EW_W-1:FRAC_BITS];
	assign alpha_new = (ewma_val > (EW_W-FRAC_BITS)'(ONE)) ? ONE : ewma_val[FRAC_W-1:0];

	assign sq_t = prod_q[2*WORK_BITS+1:WORK_BITS];
	assign vc_t = prod_q[2*WORK_BITS:WORK_BITS];
	assign e_frac = e_q[FRAC_BITS-1:0];
	assign exp_sh = SH_W'(WORK_BITS - FRAC_BITS) + SH_W'(e_q[E_W-1:FRAC_BITS]);
	assign exp_val = m_q >> exp_sh;

	// rate * factor from the two partial products
	assign full = FULL_W'({prod_q[ACC_W-1:0], {RLO_W{1'b0}}}) + FULL_W'(acc_q);
	assign dec = full[FRAC_BITS+1 +: RATE_BITS];
	assign inc = full[FRAC_BITS +: RATE_BITS+1];
	assign sum = {1'b0, rate_q} + inc;
	assign rate_next = marked_q ? (rate_q - dec)
		: (sum[RATE_BITS] ? {RATE_BITS{1'b1}} : sum[RATE_BITS-1:0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_q <= ONE;
			rate_q <= INIT_RATE_RST;
		end else begin
			if (ctl.en && (ctl.act == ACT_EWMA)) begin
				alpha_q <= alpha_new;
			end
			if (cfg_rate_we) begin
				rate_q <= cfg_rate;
			end else if (ctl.en && (ctl.act == ACT_RATE_DONE)) begin
				rate_q <= rate_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.en && (ctl.mul != MUL_NONE)) begin
			prod_q <= PROD_W'(mul_a) * PROD_W'(mul_b);
		end
		if (ctl.en) begin
			unique case (ctl.act)
				ACT_LATCH: begin
					ratio_q <= (marked_ratio > ONE) ? ONE : marked_ratio;
					w_q <= (weight > ONE) ? ONE : weight;
					marked_q <= any_marked;
				end
				ACT_ACC_LOAD: acc_q <= prod_q[ACC_W-1:0];
				ACT_POW_INIT: begin
					p_q <= ((w_q != '0) && (alpha_q == '0)) ? '0 : ONE;
					m_q <= WORK_W'(alpha_q) << (WORK_BITS - FRAC_BITS);
					k_q <= '0;
					frac_q <= '0;
					cnt_q <= CNT_W'(FRAC_BITS - 1);
				end
				ACT_NORM: begin
					if (!m_q[WORK_BITS]) begin
						m_q <= m_q << 1;
						k_q <= k_q + K_W'(1);
					end
				end
				ACT_SQ: begin
					if (sq_t[WORK_BITS+1]) begin
						m_q <= sq_t[WORK_BITS+1:1];
						frac_q[cnt_q] <= 1'b1;
					end else begin
						m_q <= sq_t[WORK_BITS:0];
					end
					cnt_q <= cnt_q - CNT_W'(1);
				end
				ACT_LOG_DONE: e_q <= {k_q, {FRAC_BITS{1'b0}}} - E_W'(frac_q);
				ACT_E_DONE: begin
					e_q <= prod_q[FRAC_BITS +: E_W];
					m_q <= W_ONE;
					cnt_q <= CNT_W'(FRAC_BITS - 1);
				end
				ACT_EXP_STEP: begin
					if (e_frac[cnt_q]) begin
						m_q <= vc_t;
					end
					cnt_q <= cnt_q - CNT_W'(1);
				end
				ACT_EXP_DONE: p_q <= exp_val[FRAC_W-1:0];
				default: ;
			endcase
		end
	end

	assign stat.marked = marked_q;
	assign stat.trivial = (w_q == '0) || (alpha_q == '0) || (alpha_q == ONE);
	assign stat.unnorm = !m_q[WORK_BITS];
	assign stat.loop = (cnt_q != '0);
	assign alpha = alpha_q;

endmodule

>>> tb/rate_update_check_pkg.sv
// Checker for the alpha/rate update block: its own fixed-point predictor and the result store.
package rate_update_check_pkg;
	import earu_pkg::*;

	typedef struct packed {
		logic [RATE_BITS-1:0] rate;
		logic [FRAC_W-1:0]    alpha;
	} rate_update_t;

	class alpha_rate_tracker;
		localparam bit [63:0] UNIT     = 64'd1 << FRAC_BITS;
		localparam bit [63:0] WUNIT    = 64'd1 << WORK_BITS;
		localparam bit [63:0] RATE_TOP = (64'd1 << RATE_BITS) - 64'd1;

		logic [FRAC_W-1:0]    gamma_q;
		logic [RATE_BITS-1:0] init_rate_q;
		logic [FRAC_W-1:0]    alpha_q;
		logic [RATE_BITS-1:0] rate_q;
		bit [63:0]            roots [FRAC_BITS];
		rate_update_t         pending_updates [$];
		int unsigned          mismatches;
		int unsigned          results_seen;

		function new();
			bit [63:0] c;
			gamma_q = GAMMA_RST;
			init_rate_q = INIT_RATE_RST;
			alpha_q = ONE;
			rate_q = INIT_RATE_RST;
			mismatches = 0;
			results_seen = 0;
			// chain of square roots of one half: 2^(-2^-j) at WORK_BITS fraction bits
			c = 64'd1 << (WORK_BITS - 1);
			for (int i = FRAC_BITS - 1; i >= 0; i--) begin
				c = root_floor(c << WORK_BITS);
				roots[i] = c;
			end
		endfunction

		function bit [63:0] root_floor(bit [63:0] x);
			bit [63:0] r;
			bit [63:0] t;
			r = 0;
			for (int b = 31; b >= 0; b--) begin
				t = r | (64'd1 << b);
				if (t * t <= x)
					r = t;
			end
			return r;
		endfunction

		function bit [63:0] clip_one(bit [63:0] v);
			return (v > UNIT) ? UNIT : v;
		endfunction

		// -log2(a) with FRAC_BITS fraction bits, 0 < a < 1
		function bit [63:0] minus_log2(bit [63:0] a);
			bit [63:0] m;
			bit [63:0] k;
			bit [63:0] frac;
			m = a << (WORK_BITS - FRAC_BITS);
			k = 0;
			frac = 0;
			while (m < WUNIT) begin
				m = m << 1;
				k++;
			end
			for (int i = FRAC_BITS - 1; i >= 0; i--) begin
				m = (m * m) >> WORK_BITS;
				if (m >= 2 * WUNIT) begin
					m = m >> 1;
					frac[i] = 1'b1;
				end
			end
			return k * UNIT - frac;
		endfunction

		function bit [63:0] pow2_neg(bit [63:0] e);
			bit [63:0] q;
			bit [63:0] r;
			bit [63:0] v;
			bit [63:0] sh;
			q = e >> FRAC_BITS;
			r = e & (UNIT - 1);
			v = WUNIT;
			for (int i = FRAC_BITS - 1; i >= 0; i--)
				if (r[i])
					v = (v * roots[i]) >> WORK_BITS;
			sh = (WORK_BITS - FRAC_BITS) + q;
			return (sh >= 64) ? 64'd0 : (v >> sh);
		endfunction

		function bit [63:0] alpha_pow(bit [63:0] a, bit [63:0] w);
			if (w == 0)
				return UNIT;
			if (a == 0)
				return 0;
			if (a >= UNIT)
				return UNIT;
			return pow2_neg((w * minus_log2(a)) >> FRAC_BITS);
		endfunction

		function void take_config(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
			if (idx == REG_GAMMA) begin
				gamma_q = data[FRAC_W-1:0];
			end else if (idx == REG_INIT_RATE) begin
				init_rate_q = data[RATE_BITS-1:0];
				rate_q = init_rate_q;
			end
		endfunction

		// Advance alpha and rate by one interval and queue the result it must give.
		function void take_request(logic [FRAC_W-1:0] ratio, logic mk, logic [FRAC_W-1:0] w);
			bit [63:0]    r;
			bit [63:0]    wt;
			bit [63:0]    g;
			bit [63:0]    a;
			bit [63:0]    rt;
			bit [63:0]    p;
			bit [63:0]    sum;
			rate_update_t upd;
			r = clip_one(64'(ratio));
			wt = clip_one(64'(w));
			g = clip_one(64'(gamma_q));
			a = clip_one(64'(alpha_q));
			rt = 64'(rate_q);
			a = clip_one(((UNIT - g) * a + g * r + (UNIT >> 1)) >> FRAC_BITS);
			if (mk) begin
				p = alpha_pow(a, wt);
				rt = rt - ((rt * p) >> (FRAC_BITS + 1));
			end else begin
				sum = rt + ((rt * wt) >> FRAC_BITS);
				rt = (sum > RATE_TOP) ? RATE_TOP : sum;
			end
			alpha_q = a[FRAC_W-1:0];
			rate_q = rt[RATE_BITS-1:0];
			upd.rate = rate_q;
			upd.alpha = alpha_q;
			pending_updates.push_back(upd);
		endfunction

		task flag_mismatch(string what, bit [63:0] got, bit [63:0] want);
			$display("MISMATCH at result %0d: %s got %0d want %0d",
				results_seen, what, got, want);
			mismatches++;
		endtask

		task match_result(logic [RATE_BITS-1:0] rate, logic [FRAC_W-1:0] alpha);
			rate_update_t upd;
			results_seen++;
			if (pending_updates.size() == 0) begin
				flag_mismatch("result with nothing pending, new_rate", 64'(rate), 0);
			end else begin
				upd = pending_updates.pop_front();
				if (rate !== upd.rate)
					flag_mismatch("new_rate", 64'(rate), 64'(upd.rate));
				if (alpha !== upd.alpha)
					flag_mismatch("new_alpha", 64'(alpha), 64'(upd.alpha));
			end
		endtask

		function int pending();
			return pending_updates.size();
		endfunction
	endclass

endpackage

>>> tb/tb_top.sv
// Top of the testbench for the alpha/rate update block: clock, reset, drivers and run control.
module tb_top;
	import earu_pkg::*;
	import rate_update_check_pkg::*;

	// the cycle limit is many times the length of the slowest full power pass
	localparam int unsigned CYCLE_LIMIT    = 1_000_000;
	localparam int          RANDOM_PHASES  = 8;
	localparam int          PHASE_REQUESTS = 180;
	localparam int          SETTLE_CYCLES  = 120;

	logic                 clk;
	logic                 arst_n = 1'b0;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0]     cfg_data = '0;
	logic                 in_valid = 1'b0;
	logic                 in_ready;
	logic [FRAC_W-1:0]    marked_ratio = '0;
	logic                 any_marked = 1'b0;
	logic [FRAC_W-1:0]    weight = '0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	logic [RATE_BITS-1:0] new_rate;
	logic [FRAC_W-1:0]    new_alpha;

	alpha_rate_tracker tracker = new();

	int  send_idle_pct = 0;
	int  stall_pct = 0;
	bit  drain_before_next = 1'b0;
	int  requests_sent = 0;
	int  phases_run = 0;

	ecn_alpha_rate_update u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.marked_ratio (marked_ratio),
		.any_marked   (any_marked),
		.weight       (weight),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.new_rate     (new_rate),
		.new_alpha    (new_alpha)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Receiver: stall at random in the phases that ask for it, change only at the falling edge.
	always @(negedge clk) begin
		out_ready <= ($urandom_range(99) >= stall_pct);
	end

	// Check every result the block hands over at the rising edge.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			tracker.match_result(new_rate, new_alpha);
	end

	// Watchdog: end the run if the block stops making progress.
	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("Run stopped after %0d cycles with %0d results still pending",
			CYCLE_LIMIT, tracker.pending());
		$display("FAILED: results differ");
		$finish;
	end

	// Write one register; call at a falling edge, return at a falling edge with the enable low.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		tracker.take_config(idx, data);
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	// Offer one request and hold it until accepted. Idle the sender first when the
	// phase asks, or pause until every pending result is out. Entered and left at a
	// falling edge; valid stays high on return so back-to-back requests need no gap.
	task automatic push_request(input logic [FRAC_W-1:0] ratio, input logic mk,
			input logic [FRAC_W-1:0] w);
		if (drain_before_next || ($urandom_range(99) < send_idle_pct)) begin
			in_valid <= 1'b0;
			do
				@(negedge clk);
			while (!drain_before_next && ($urandom_range(99) < send_idle_pct));
			while (drain_before_next && (tracker.pending() != 0))
				@(negedge clk);
			drain_before_next = 1'b0;
		end
		marked_ratio <= ratio;
		any_marked <= mk;
		weight <= w;
		in_valid <= 1'b1;
		do
			@(posedge clk);
		while (!in_ready);
		tracker.take_request(ratio, mk, w);
		requests_sent++;
		@(negedge clk);
	endtask

	// Drop valid and wait until the block has handed over everything pending.
	task automatic drain_results();
		in_valid <= 1'b0;
		@(negedge clk);
		while (tracker.pending() != 0)
			@(negedge clk);
	endtask

	// Pick a fraction: mostly in range, with zero, one, tiny values and over-range values.
	function automatic logic [FRAC_W-1:0] pick_frac();
		case ($urandom_range(9))
			0: return '0;
			1: return ONE;
			2: return FRAC_W'($urandom_range(1, 64));
			3: return FRAC_W'($urandom_range(65537, 131071));
			default: return FRAC_W'($urandom_range(0, 65536));
		endcase
	endfunction

	task automatic set_idle_mode(input int mode);
		case (mode)
			1: begin
				send_idle_pct = 70;
				stall_pct = 0;
			end
			2: begin
				send_idle_pct = 0;
				stall_pct = 70;
			end
			3: begin
				send_idle_pct = 37;
				stall_pct = 37;
			end
			default: begin
				send_idle_pct = 0;
				stall_pct = 0;
			end
		endcase
	endtask

	initial begin
		logic [FRAC_W-1:0]    g_val;
		logic [RATE_BITS-1:0] r_val;
		logic [CFG_W-1:0]     upper;

		// hold reset, then release it at a falling edge
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed part, reset settings, no idling.
		set_idle_mode(0);
		push_request('0, 1'b0, '0);
		push_request(ONE, 1'b1, ONE);
		// zero weight: the power is one and the rate halves
		push_request(ONE, 1'b1, '0);
		// drive alpha down toward zero step by step, covering normalization shifts up to the largest
		// and finally the zero-alpha power
		repeat (13) push_request('0, 1'b1, ONE);
		// fractions above one are clipped
		push_request('1, 1'b1, '1);
		push_request(ONE, 1'b0, ONE);
		drain_results();
		phases_run++;

		// over-range gamma and the widest rate: the increase saturates
		write_reg(REG_GAMMA, CFG_W'('1));
		write_reg(REG_INIT_RATE, CFG_W'('1));
		push_request('1, 1'b0, ONE);
		push_request(FRAC_W'(12345), 1'b1, FRAC_W'(40000));
		drain_results();
		phases_run++;

		// zero rate stays zero; zero gamma freezes alpha
		write_reg(REG_GAMMA, '0);
		write_reg(REG_INIT_RATE, '0);
		push_request(ONE, 1'b0, ONE);
		push_request('0, 1'b1, ONE);
		drain_results();
		phases_run++;

		// Random part: a new setting and idle pattern per phase.
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			case (p)
				0: g_val = ONE;
				1: g_val = '0;
				3: g_val = FRAC_W'($urandom_range(0, 131071));
				4: g_val = FRAC_W'(1);
				5: g_val = FRAC_W'(65535);
				7: g_val = GAMMA_RST;
				default: g_val = FRAC_W'($urandom_range(0, 65536));
			endcase
			case (p)
				0: r_val = INIT_RATE_RST;
				1: r_val = '1;
				2: r_val = RATE_BITS'(1);
				4: r_val = RATE_BITS'($urandom_range(1000, 100000));
				7: r_val = RATE_BITS'(10000000);
				default: r_val = RATE_BITS'({$urandom, $urandom});
			endcase
			// unused upper bits of the gamma write carry noise
			upper = CFG_W'({$urandom, $urandom});
			write_reg(REG_GAMMA, {upper[CFG_W-1:FRAC_W], g_val});
			write_reg(REG_INIT_RATE, CFG_W'(r_val));
			set_idle_mode(p % 4);
			for (int n = 0; n < PHASE_REQUESTS; n++) begin
				// halfway through, hold the sender until the block is empty
				if (n == PHASE_REQUESTS / 2)
					drain_before_next = 1'b1;
				push_request(pick_frac(), 1'($urandom_range(1)), pick_frac());
			end
			drain_results();
			phases_run++;
		end

		// let any stray result show up before the verdict
		set_idle_mode(0);
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("Sent %0d update requests and checked %0d results over %0d settings,",
			requests_sent, tracker.results_seen, phases_run);
		$display("with gamma and initial rate at both extremes and idle, stall and drain patterns.");
		if (tracker.mismatches == 0 && tracker.pending() == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule
